// ===== design/hbt_pkg.sv =====
package hbt_pkg;

  localparam int unsigned BUCKETS_DEF = 1024;
  localparam int unsigned WAYS_DEF    = 4;

  localparam int unsigned HASH_W    = 32;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned STATUS_W  = 2;
  // remainder by the bucket count takes two steps: quotient, then remainder
  localparam int unsigned MOD_STEPS = 2;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_TAKE,
    OP_FIN1,
    OP_FIN2,
    OP_FIN3,
    OP_MOD,
    OP_FILL_RD,
    OP_INSERT,
    OP_LK_RD,
    OP_LK_CMP,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic clr_last;
    logic in_kind;
    logic in_last;
    logic is_lookup;
    logic mod_done;
    logic way_end;
    logic hit;
    logic out_free;
  } hbt_stat_t;

endpackage

// ===== design/hbt_ctrl.sv =====
module hbt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hbt_pkg::hbt_stat_t stat_i,
  output hbt_pkg::dp_op_e    op_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_FIN1   = 4'd2;
  localparam logic [3:0] S_FIN2   = 4'd3;
  localparam logic [3:0] S_FIN3   = 4'd4;
  localparam logic [3:0] S_MOD    = 4'd5;
  localparam logic [3:0] S_FILL   = 4'd6;
  localparam logic [3:0] S_INS    = 4'd7;
  localparam logic [3:0] S_LK_RD  = 4'd8;
  localparam logic [3:0] S_LK_CMP = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = hbt_pkg::OP_NONE;
    case (state_q)
      S_CLEAR: begin
        op_o = hbt_pkg::OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = hbt_pkg::OP_TAKE;
          if (stat_i.in_kind)      state_d = S_MOD;
          else if (stat_i.in_last) state_d = S_FIN1;
        end
      end
      S_FIN1: begin
        op_o    = hbt_pkg::OP_FIN1;
        state_d = S_FIN2;
      end
      S_FIN2: begin
        op_o    = hbt_pkg::OP_FIN2;
        state_d = S_FIN3;
      end
      S_FIN3: begin
        op_o    = hbt_pkg::OP_FIN3;
        state_d = S_MOD;
      end
      S_MOD: begin
        op_o = hbt_pkg::OP_MOD;
        if (stat_i.mod_done) state_d = S_FILL;
      end
      S_FILL: begin
        op_o    = hbt_pkg::OP_FILL_RD;
        state_d = stat_i.is_lookup ? S_LK_RD : S_INS;
      end
      S_INS: begin
        op_o    = hbt_pkg::OP_INSERT;
        state_d = S_DONE;
      end
      S_LK_RD: begin
        op_o    = hbt_pkg::OP_LK_RD;
        state_d = stat_i.way_end ? S_DONE : S_LK_CMP;
      end
      S_LK_CMP: begin
        op_o    = hbt_pkg::OP_LK_CMP;
        state_d = stat_i.hit ? S_DONE : S_LK_RD;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (stat_i.out_free) begin
          op_o    = hbt_pkg::OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/hbt_dp.sv =====
module hbt_dp #(
  parameter int unsigned BUCKETS = hbt_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = hbt_pkg::WAYS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hbt_pkg::dp_op_e                     op_i,
  input  logic                                in_kind_i,
  input  logic [7:0]                          in_key_byte_i,
  input  logic                                in_last_byte_i,
  input  logic signed [hbt_pkg::VALUE_W-1:0]  in_value_i,
  input  logic [hbt_pkg::HASH_W-1:0]          in_hash_in_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [hbt_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [hbt_pkg::VALUE_W-1:0]  out_found_value_o,
  output logic [hbt_pkg::HASH_W-1:0]          out_key_hash_o,
  output hbt_pkg::hbt_stat_t                  stat_o
);

  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned FILL_W  = $clog2(WAYS + 1);
  localparam int unsigned ENTRIES = BUCKETS * WAYS;
  localparam int unsigned ENT_W   = $clog2(ENTRIES);
  localparam int unsigned HW      = hbt_pkg::HASH_W;
  localparam int unsigned VW      = hbt_pkg::VALUE_W;
  // rounded-up reciprocal of the bucket count, exact for any 32-bit dividend
  localparam logic [HW:0] RECIP   =
    (HW + 1)'(((64'd1 << (HW + BKT_W)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  logic [FILL_W-1:0] fill_mem     [BUCKETS];
  logic [HW-1:0]     ent_hash_mem [ENTRIES];
  logic [VW-1:0]     ent_val_mem  [ENTRIES];

  logic [HW-1:0]                 running_q;
  logic [HW-1:0]                 work_q;
  logic [VW-1:0]                 value_q;
  logic                          kind_q;
  logic [HW-1:0]                 div_q;
  logic [HW-1:0]                 quot_q;
  logic [BKT_W-1:0]              rem_q;
  logic [hbt_pkg::MOD_CNT_W-1:0] step_q;
  logic [FILL_W-1:0]             fill_q;
  logic [FILL_W-1:0]             way_q;
  logic [BKT_W-1:0]              clr_q;
  logic [HW-1:0]                 ent_hash_rd_q;
  logic [VW-1:0]                 ent_val_rd_q;
  logic [hbt_pkg::STATUS_W-1:0]  res_status_q;
  logic [VW-1:0]                 res_fval_q;
  logic                          out_valid_q;
  logic [hbt_pkg::STATUS_W-1:0]  out_status_q;
  logic [VW-1:0]                 out_fval_q;
  logic [HW-1:0]                 out_hash_q;

  logic [HW-1:0]     fold_h;
  logic [HW-1:0]     fin1_h;
  logic [HW-1:0]     fin2_h;
  logic [HW-1:0]     abs_h;
  logic [2*HW+1:0]   recip_prod;
  logic [HW-1:0]     quot_nxt;
  logic [HW-1:0]     rem_full;
  logic [BKT_W-1:0]  rem_nxt;
  logic              full;
  logic              way_end;
  logic [FILL_W-1:0] ent_way;
  logic [ENT_W-1:0]  ent_addr;

  // fold one sign-extended key byte into the running hash
  always_comb begin
    logic [HW-1:0] h;
    h      = running_q + {{(HW-8){in_key_byte_i[7]}}, in_key_byte_i};
    h      = h + (h << 10);
    fold_h = h ^ (h >> 6);
  end

  always_comb begin
    logic [HW-1:0] h;
    h      = work_q + (work_q << 3);
    fin1_h = h ^ (h >> 11);
  end

  assign fin2_h = work_q + (work_q << 15);
  assign abs_h  = work_q[HW-1] ? (~work_q + 1'b1) : work_q;

  // quotient by reciprocal multiply on the first step, remainder by subtract on the second
  assign recip_prod = (2*HW+2)'(div_q) * (2*HW+2)'(RECIP);
  assign quot_nxt   = HW'(recip_prod >> (HW + BKT_W));
  assign rem_full   = div_q - quot_q * HW'(BUCKETS);
  assign rem_nxt    = rem_full[BKT_W-1:0];

  assign full     = (fill_q >= FILL_W'(WAYS));
  assign way_end  = (way_q == fill_q);
  assign ent_way  = (op_i == hbt_pkg::OP_INSERT) ? fill_q : way_q;
  assign ent_addr = ENT_W'(rem_q) * ENT_W'(WAYS) + ENT_W'(ent_way);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == hbt_pkg::OP_CLEAR) clr_q <= clr_q + 1'b1;
      if (op_i == hbt_pkg::OP_TAKE && !in_kind_i) begin
        running_q <= in_last_byte_i ? '0 : fold_h;
      end
      if (op_i == hbt_pkg::OP_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i)         out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      hbt_pkg::OP_TAKE: begin
        kind_q  <= in_kind_i;
        value_q <= in_value_i;
        work_q  <= in_kind_i ? in_hash_in_i : fold_h;
        div_q   <= in_hash_in_i;
        rem_q   <= '0;
        step_q  <= '0;
      end
      hbt_pkg::OP_FIN1: work_q <= fin1_h;
      hbt_pkg::OP_FIN2: work_q <= fin2_h;
      hbt_pkg::OP_FIN3: begin
        work_q <= abs_h;
        div_q  <= abs_h;
        rem_q  <= '0;
        step_q <= '0;
      end
      hbt_pkg::OP_MOD: begin
        if (step_q == '0) quot_q <= quot_nxt;
        else              rem_q  <= rem_nxt;
        step_q <= step_q + 1'b1;
      end
      hbt_pkg::OP_FILL_RD: way_q <= '0;
      hbt_pkg::OP_INSERT: begin
        res_status_q <= full ? hbt_pkg::ST_FULL : hbt_pkg::ST_INSERTED;
        res_fval_q   <= '1;
      end
      hbt_pkg::OP_LK_RD: begin
        if (way_end) begin
          res_status_q <= hbt_pkg::ST_NOT_FOUND;
          res_fval_q   <= '1;
        end
      end
      hbt_pkg::OP_LK_CMP: begin
        if (ent_hash_rd_q == work_q) begin
          res_status_q <= hbt_pkg::ST_FOUND;
          res_fval_q   <= ent_val_rd_q;
        end else begin
          way_q <= way_q + 1'b1;
        end
      end
      hbt_pkg::OP_EMIT: begin
        out_status_q <= res_status_q;
        out_fval_q   <= res_fval_q;
        out_hash_q   <= work_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op_i == hbt_pkg::OP_CLEAR) begin
      fill_mem[clr_q] <= '0;
    end else if (op_i == hbt_pkg::OP_INSERT && !full) begin
      fill_mem[rem_q] <= fill_q + 1'b1;
    end
    if (op_i == hbt_pkg::OP_FILL_RD) fill_q <= fill_mem[rem_q];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == hbt_pkg::OP_INSERT && !full) begin
      ent_hash_mem[ent_addr] <= work_q;
      ent_val_mem[ent_addr]  <= value_q;
    end
    if (op_i == hbt_pkg::OP_LK_RD && !way_end) begin
      ent_hash_rd_q <= ent_hash_mem[ent_addr];
      ent_val_rd_q  <= ent_val_mem[ent_addr];
    end
  end

  assign stat_o.clr_last  = (clr_q == BKT_W'(BUCKETS - 1));
  assign stat_o.in_kind   = in_kind_i;
  assign stat_o.in_last   = in_last_byte_i;
  assign stat_o.is_lookup = kind_q;
  assign stat_o.mod_done  = (step_q == hbt_pkg::MOD_CNT_W'(hbt_pkg::MOD_STEPS - 1));
  assign stat_o.way_end   = way_end;
  assign stat_o.hit       = (ent_hash_rd_q == work_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_found_value_o = out_fval_q;
  assign out_key_hash_o    = out_hash_q;

endmodule

// ===== design/hashed_bucket_table.sv =====
// channel | direction | handshake                | beat fields
// in      | input     | in_valid_i / in_ready_o  | kind, key_byte, last_byte, value, hash_in
// out     | output    | out_valid_o / out_ready_i| status, found_value, key_hash
//
// A non-final key byte is only folded into the running hash. A final key byte is folded,
// then goes through three finalise steps, remainder by BUCKETS (reciprocal multiply, then
// subtract), fill read, write and emit.
// A lookup takes hash_in modulo BUCKETS, reads the fill, then reads the ways in turn until a hit;
// each way costs one entry memory read and one compare.
// After reset the bucket fill memory is cleared one bucket a cycle, with in_ready_o low
// throughout. A finished result is held in the output register while the next beat is
// taken; the block stalls only when a second result is ready before the first is taken.
module hashed_bucket_table #(
  parameter int unsigned BUCKETS = hbt_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = hbt_pkg::WAYS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_kind_i,
  input  logic [7:0]                          in_key_byte_i,
  input  logic                                in_last_byte_i,
  input  logic signed [hbt_pkg::VALUE_W-1:0]  in_value_i,
  input  logic [hbt_pkg::HASH_W-1:0]          in_hash_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hbt_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [hbt_pkg::VALUE_W-1:0]  out_found_value_o,
  output logic [hbt_pkg::HASH_W-1:0]          out_key_hash_o
);

  hbt_pkg::dp_op_e    op;
  hbt_pkg::hbt_stat_t stat;

  hbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  hbt_dp #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .in_kind_i         (in_kind_i),
    .in_key_byte_i     (in_key_byte_i),
    .in_last_byte_i    (in_last_byte_i),
    .in_value_i        (in_value_i),
    .in_hash_in_i      (in_hash_in_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .out_status_o      (out_status_o),
    .out_found_value_o (out_found_value_o),
    .out_key_hash_o    (out_key_hash_o),
    .stat_o            (stat)
  );

endmodule

// ===== design/hbt_checker.sv =====
module hbt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [hbt_pkg::STATUS_W-1:0]       out_status_o,
  input logic signed [hbt_pkg::VALUE_W-1:0] out_found_value_o,
  input logic [hbt_pkg::HASH_W-1:0]         out_key_hash_o
);

  // a stalled result beat stays up and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_status_o)
      && $stable(out_found_value_o) && $stable(out_key_hash_o))
    else $error("result beat changed while stalled");

  a_fval_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o != hbt_pkg::ST_FOUND |-> out_found_value_o == -32'sd1)
    else $error("found_value not all ones without a hit");

  // an inserted key hash has been through the absolute value
  a_hash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == hbt_pkg::ST_INSERTED || out_status_o == hbt_pkg::ST_FULL)
      |-> !out_key_hash_o[31] || out_key_hash_o[30:0] == 31'd0)
    else $error("insert key hash above 2^31");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("input taken during the clearing pass");

endmodule

bind hashed_bucket_table hbt_checker u_hbt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .out_status_o      (out_status_o),
  .out_found_value_o (out_found_value_o),
  .out_key_hash_o    (out_key_hash_o)
);

// ===== test/hashed_bucket_table_tb.sv =====
module hashed_bucket_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hbt_pkg::*;

  localparam int unsigned BUCKETS        = BUCKETS_DEF;
  localparam int unsigned WAYS           = WAYS_DEF;
  localparam int unsigned ITEMS          = 900;
  localparam int unsigned PHASE_BEATS    = 110;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES    = 60;
  localparam int unsigned CYCLE_LIMIT    = 400_000;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // inverses of the odd multipliers used by the hash, modulo 2**32
  localparam logic [31:0] INV_9     = 32'h38E3_8E39;
  localparam logic [31:0] INV_1025  = 32'hC00F_FC01;
  localparam logic [31:0] INV_32769 = 32'h3FFF_8001;
  localparam int unsigned SLOT_BITS = 20;

  typedef struct {
    logic                      kind;
    logic [7:0]                key_byte;
    logic                      last;
    logic signed [VALUE_W-1:0] value;
    logic [HASH_W-1:0]         hash_in;
    int unsigned               idle_pct;
    int unsigned               stall_pct;
    bit                        drain_first;
    bit                        hold_rx;
  } beat_t;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] found_value;
    logic [HASH_W-1:0]         key_hash;
  } answer_t;

  typedef struct {
    logic [47:0] bytes;
    int unsigned len;
  } key_rec_t;

  logic                      clk_i             = 1'b0;
  logic                      rst_ni            = 1'b0;
  logic                      in_valid_i        = 1'b0;
  logic                      in_ready_o;
  logic                      in_kind_i         = KIND_INSERT;
  logic [7:0]                in_key_byte_i     = '0;
  logic                      in_last_byte_i    = 1'b0;
  logic signed [VALUE_W-1:0] in_value_i        = '0;
  logic [HASH_W-1:0]         in_hash_in_i      = '0;
  logic                      out_valid_o;
  logic                      out_ready_i       = 1'b0;
  logic [STATUS_W-1:0]       out_status_o;
  logic signed [VALUE_W-1:0] out_found_value_o;
  logic [HASH_W-1:0]         out_key_hash_o;

  hashed_bucket_table #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_kind_i        (in_kind_i),
    .in_key_byte_i    (in_key_byte_i),
    .in_last_byte_i   (in_last_byte_i),
    .in_value_i       (in_value_i),
    .in_hash_in_i     (in_hash_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_status_o     (out_status_o),
    .out_found_value_o(out_found_value_o),
    .out_key_hash_o   (out_key_hash_o)
  );

  // table image kept alongside the block
  logic [HASH_W-1:0]         run_hash = '0;
  int unsigned               fill_cnt   [BUCKETS];
  logic [HASH_W-1:0]         slot_hash  [BUCKETS][WAYS];
  logic signed [VALUE_W-1:0] slot_value [BUCKETS][WAYS];

  beat_t       beat_q[$];
  answer_t     answer_q[$];
  key_rec_t    key_pool[$];
  logic [31:0] hash_pool[$];
  beat_t       on_wire;

  int unsigned gen_count    = 0;
  int unsigned beats_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned gen_idle     = 0;
  int unsigned gen_stall    = 0;
  bit          mark_drain   = 1'b0;
  bit          mark_hold    = 1'b0;
  int unsigned rx_stall_pct = 0;
  logic        hold_req     = 1'b0;
  int unsigned hold_left    = 0;

  int unsigned fwd_slot [1 << SLOT_BITS];

  function automatic logic [31:0] fold_key_byte(logic [31:0] h, logic [7:0] b);
    h = h + {{24{b[7]}}, b};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  function automatic logic [31:0] finalise_hash(logic [31:0] h);
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    if (h[31]) h = 32'd0 - h;
    return h;
  endfunction

  function automatic logic [31:0] key_digest(key_rec_t k);
    logic [31:0] h;
    h = '0;
    for (int unsigned n = 0; n < k.len; n++) h = fold_key_byte(h, k.bytes[8*n +: 8]);
    return finalise_hash(h);
  endfunction

  function automatic logic [31:0] unshift_xor(logic [31:0] y, int unsigned s);
    logic [31:0] x;
    x = y;
    repeat (32 / s + 1) x = y ^ (x >> s);
    return x;
  endfunction

  function automatic logic [31:0] unfold_key_byte(logic [31:0] h, logic [7:0] b);
    return unshift_xor(h, 6) * INV_1025 - {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] prefix_hash(int unsigned i);
    logic [31:0] h;
    h = fold_key_byte(32'd0, i[7:0]);
    h = fold_key_byte(h, i[15:8]);
    return fold_key_byte(h, {6'd0, i[17:16]});
  endfunction

  // Meet in the middle: a six byte key whose hash is 0x80000000 before the
  // absolute value, which must come through unchanged.
  function automatic key_rec_t min_int_key();
    key_rec_t    k;
    logic [31:0] tgt;
    logic [31:0] h;
    int unsigned i;
    tgt = unshift_xor(32'h8000_0000 * INV_32769, 11) * INV_9;
    for (int unsigned p = 0; p < (1 << 18); p++) fwd_slot[prefix_hash(p) % (1 << SLOT_BITS)] = p + 1;
    k.len   = 0;
    k.bytes = '0;
    for (int unsigned j = 0; j < (1 << 24) && k.len == 0; j++) begin
      h = unfold_key_byte(tgt, j[7:0]);
      h = unfold_key_byte(h, j[15:8]);
      h = unfold_key_byte(h, j[23:16]);
      i = fwd_slot[h % (1 << SLOT_BITS)];
      if (i != 0 && prefix_hash(i - 1) == h) begin
        i = i - 1;
        k.bytes = {j[7:0], j[15:8], j[23:16], 6'd0, i[17:16], i[15:8], i[7:0]};
        k.len   = 6;
      end
    end
    return k;
  endfunction

  function automatic void table_access(beat_t b);
    answer_t     ans;
    int unsigned bkt;
    int unsigned fill;
    ans.found_value = -1;
    if (b.kind == KIND_INSERT) begin
      run_hash = fold_key_byte(run_hash, b.key_byte);
      if (!b.last) return;
      ans.key_hash = finalise_hash(run_hash);
      run_hash     = '0;
      bkt          = ans.key_hash % BUCKETS;
      fill         = fill_cnt[bkt];
      if (fill < WAYS) begin
        slot_hash[bkt][fill]  = ans.key_hash;
        slot_value[bkt][fill] = b.value;
        fill_cnt[bkt]         = fill + 1;
        ans.status            = ST_INSERTED;
      end else begin
        ans.status = ST_FULL;
      end
    end else begin
      ans.key_hash = b.hash_in;
      ans.status   = ST_NOT_FOUND;
      bkt          = b.hash_in % BUCKETS;
      for (int unsigned w = 0; w < fill_cnt[bkt]; w++) begin
        if (slot_hash[bkt][w] == b.hash_in) begin
          ans.status      = ST_FOUND;
          ans.found_value = slot_value[bkt][w];
          break;
        end
      end
    end
    answer_q.push_back(ans);
  endfunction

  task automatic push_beat(beat_t b);
    b.idle_pct    = gen_idle;
    b.stall_pct   = gen_stall;
    b.drain_first = mark_drain;
    b.hold_rx     = mark_hold;
    mark_drain    = 1'b0;
    mark_hold     = 1'b0;
    beat_q.push_back(b);
    gen_count++;
  endtask

  task automatic push_lookup(logic [31:0] h);
    beat_t b;
    b.kind     = KIND_LOOKUP;
    b.key_byte = 8'($urandom);
    b.last     = 1'($urandom);
    b.value    = $urandom;
    b.hash_in  = h;
    push_beat(b);
  endtask

  task automatic push_key(key_rec_t k, logic signed [31:0] v, int unsigned mid_pct);
    beat_t b;
    for (int unsigned n = 0; n < k.len; n++) begin
      // interleave a lookup while the key is still open
      if (n != 0 && hash_pool.size() != 0 && $urandom_range(0, 99) < mid_pct)
        push_lookup(hash_pool[$urandom_range(0, hash_pool.size() - 1)]);
      b.kind     = KIND_INSERT;
      b.key_byte = k.bytes[8*n +: 8];
      b.last     = (n == k.len - 1);
      b.value    = b.last ? v : $urandom;
      b.hash_in  = $urandom;
      push_beat(b);
    end
    key_pool.push_back(k);
    hash_pool.push_back(key_digest(k));
  endtask

  task automatic random_txn();
    key_rec_t    k;
    int unsigned pick;
    int unsigned back;
    pick = $urandom_range(0, 99);
    if (pick < 50 || key_pool.size() == 0) begin
      k.len   = $urandom_range(1, 6);
      k.bytes = {16'($urandom), 32'($urandom)};
      push_key(k, $urandom, 8);
    end else if (pick < 62) begin
      // reinsert a recent key to build duplicates and full buckets
      back = $urandom_range(0, key_pool.size() > 4 ? 3 : key_pool.size() - 1);
      push_key(key_pool[key_pool.size() - 1 - back], $urandom, 8);
    end else if (pick < 85) begin
      push_lookup(hash_pool[$urandom_range(0, hash_pool.size() - 1)]);
    end else if (pick < 93) begin
      // same bucket, different hash
      push_lookup(hash_pool[$urandom_range(0, hash_pool.size() - 1)] ^
                  (32'($urandom_range(1, 32'h3F_FFFF)) << $clog2(BUCKETS)));
    end else begin
      push_lookup($urandom);
    end
  endtask

  task automatic check_answer();
    answer_t want;
    if (answer_q.size() == 0) begin
      if (mismatches < 10)
        $display("result %0d unexpected: status %0d value %0d hash %08h", results_seen,
                 out_status_o, out_found_value_o, out_key_hash_o);
      mismatches++;
    end else begin
      want = answer_q.pop_front();
      if (out_status_o !== want.status || out_found_value_o !== want.found_value ||
          out_key_hash_o !== want.key_hash) begin
        if (mismatches < 10)
          $display("result %0d: expected status %0d value %0d hash %08h, got %0d %0d %08h",
                   results_seen, want.status, want.found_value, want.key_hash,
                   out_status_o, out_found_value_o, out_key_hash_o);
        mismatches++;
      end
    end
    results_seen++;
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive
    beat_t nxt;
    bit    go;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      hold_req   <= 1'b0;
    end else begin
      go = 1'b0;
      if (in_valid_i && in_ready_o) begin
        table_access(on_wire);
        beats_taken++;
      end
      // advance only once the current beat has gone
      if (!in_valid_i || in_ready_o) begin
        if (beat_q.size() != 0) begin
          nxt = beat_q[0];
          go  = (!nxt.drain_first || answer_q.size() == 0) &&
                ($urandom_range(0, 99) >= nxt.idle_pct);
        end
        if (go) begin
          beat_q.delete(0);
          on_wire = nxt;
          in_kind_i      <= nxt.kind;
          in_key_byte_i  <= nxt.key_byte;
          in_last_byte_i <= nxt.last;
          in_value_i     <= nxt.value;
          in_hash_in_i   <= nxt.hash_in;
          rx_stall_pct   <= nxt.stall_pct;
        end
        in_valid_i <= go;
      end
      hold_req <= go && nxt.hold_rx;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= RX_HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_answer();
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    key_rec_t    k;
    int unsigned phase_end;

    // empty table, extreme hashes
    push_lookup(32'h0000_0000);
    push_lookup(32'hFFFF_FFFF);
    k.len   = 1;
    k.bytes = 48'h00;
    push_key(k, 32'h7FFF_FFFF, 0);
    k.bytes = 48'hFF;
    push_key(k, 32'h8000_0000, 0);
    // zero byte inside the key, lookups while it is open
    k.len   = 3;
    k.bytes = 48'h7F_00_80;
    push_key(k, 32'h1234_5678, 100);
    push_lookup(hash_pool[0]);
    k = min_int_key();
    if (k.len != 0) push_key(k, 32'd5, 0);
    push_lookup(32'h8000_0000);
    // duplicates up to a full bucket, then first-match and miss in that bucket
    k.len   = 1;
    k.bytes = 48'h41;
    for (int v = 1; v <= 5; v++) push_key(k, v, 0);
    push_lookup(hash_pool[hash_pool.size() - 1]);
    push_lookup(hash_pool[hash_pool.size() - 1] ^ 32'h8000_0000);

    for (int unsigned ph = 0; gen_count < ITEMS; ph++) begin
      case (ph % 5)
        0: begin gen_idle = 0;  gen_stall = 0;  end
        1: begin gen_idle = 83; gen_stall = 0;  end
        2: begin gen_idle = 0;  gen_stall = 83; end
        3: begin gen_idle = 26; gen_stall = 26; end
        default: begin gen_idle = 0; gen_stall = 0; end
      endcase
      mark_drain = 1'b1;
      phase_end  = gen_count + PHASE_BEATS;
      if (ph % 5 == 4) begin
        // long receiver hold with short items streaming behind it
        mark_hold = 1'b1;
        repeat (30) begin
          if ($urandom_range(0, 1) == 0 || hash_pool.size() == 0) begin
            k.len   = 1;
            k.bytes = 48'($urandom_range(0, 255));
            push_key(k, $urandom, 0);
          end else begin
            push_lookup(hash_pool[$urandom_range(0, hash_pool.size() - 1)]);
          end
        end
      end
      while (gen_count < phase_end) random_txn();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken != gen_count) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
